>>> design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define CFET_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cfet assertion failed");

// Same-cycle implication checked outside reset.
`define CFET_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfet assertion failed");

`endif

>>> design/cfet_pkg.sv
// ----------------------------------------------------------------------------
// cfet_pkg
// Shared constants, codes and types of the free extent table.
// ----------------------------------------------------------------------------
`default_nettype none

package cfet_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int ADDR_BITS   = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // One free extent, kept as first and inclusive last address.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] last;
  } extent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    extent_t          wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> design/cfet_store.sv
// ----------------------------------------------------------------------------
// cfet_store
// Extent memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfet_store import cfet_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output extent_t  rdata
);

  extent_t mem [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

>>> design/coalescing_free_extent_table.sv
// ----------------------------------------------------------------------------
// coalescing_free_extent_table
// Sorted table of free extents with merge on free and split on allocate.
// ----------------------------------------------------------------------------
// Each word is handled alone. The scan of the extent memory reads one entry per
// cycle; the steps for the sum and the range check come before it, and the steps
// for the decision, the writes and the result come after it. When entries must
// move up or down by one slot to open or close a place, a shift step is added
// between the writes. The single read port of the extent memory serves both the
// scan and the shift. A zero length or an out-of-range word skips the scan and
// goes straight to the result. The result sits in an output register; the next
// word is taken once the result has been loaded there.
`default_nettype none

module coalescing_free_extent_table import cfet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [63:0] start_address,
  input  logic [63:0] length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] merged_start,
  output logic [63:0] merged_size
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_CHECK, S_SCAN, S_DECIDE, S_WR1, S_SHIFT, S_WR2, S_FINISH
  } state_t;

  state_t state;

  mem_req_t mem_req;
  extent_t  rdata;

  logic             act;
  logic [63:0]      start_r, len_r, startm1, lastp1, last_r;
  logic             carry;
  logic [CNT_W-1:0] n;

  // Scan bookkeeping.
  logic [CNT_W-1:0] ri;
  logic             dv;
  logic [IDX_W-1:0] di;
  logic             found, ovl, lo_f, hi_f, pos_f;
  logic [IDX_W-1:0] hit_idx, lo_idx, hi_idx;
  logic [CNT_W-1:0] pos_idx;
  logic [63:0]      hit_base, hit_last, lo_base, hi_last;

  // Plan of the update.
  logic             w1_en, w2_en, sh_en, sh_open;
  logic [IDX_W-1:0] w1_a, w2_a;
  extent_t          w1_d, w2_d;
  logic [CNT_W-1:0] sc, rem;
  logic [IDX_W-1:0] wa;
  logic [1:0]       status_r;
  logic             merged;
  logic [63:0]      m_base, m_last;

  logic [64:0]      sum;
  logic             hit_left, hit_right, full, whole_space;
  logic [63:0]      mbase, mlast;
  logic             issue, sh_issue;

  assign in_ready = (state == S_IDLE);
  assign sum      = {1'b0, start_r} + {1'b0, len_r};

  assign hit_left    = hit_base < start_r;
  assign hit_right   = hit_last > last_r;
  assign full        = (n == CNT_W'(MAX_EXTENTS));
  assign mbase       = lo_f ? lo_base : start_r;
  assign mlast       = hi_f ? hi_last : last_r;
  assign whole_space = (mbase == 64'd0) && (mlast == {64{1'b1}});

  assign issue    = (ri < n);
  assign sh_issue = (rem != '0);

  cfet_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_comb begin
    mem_req.raddr = (state == S_SHIFT) ? sc[IDX_W-1:0] : ri[IDX_W-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = w1_a;
    mem_req.wdata = w1_d;
    case (state)
      S_WR1: begin
        mem_req.we = w1_en;
      end
      S_WR2: begin
        mem_req.we    = w2_en;
        mem_req.waddr = w2_a;
        mem_req.wdata = w2_d;
      end
      S_SHIFT: begin
        mem_req.we    = dv;
        mem_req.waddr = wa;
        mem_req.wdata = rdata;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act     <= action;
            start_r <= start_address;
            len_r   <= length;
            startm1 <= start_address - 64'd1;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          lastp1 <= sum[63:0];
          carry  <= sum[64];
          state  <= S_CHECK;
        end
        S_CHECK: begin
          last_r   <= lastp1 - 64'd1;
          merged   <= 1'b0;
          ri       <= '0;
          dv       <= 1'b0;
          found    <= 1'b0;
          ovl      <= 1'b0;
          lo_f     <= 1'b0;
          hi_f     <= 1'b0;
          pos_f    <= 1'b0;
          if (len_r == 64'd0) begin
            status_r <= ST_DONE;
            state    <= S_FINISH;
          end else if (start_r > ADDR_MASK || (lastp1 - 64'd1) > ADDR_MASK
                       || (carry && lastp1 != 64'd0)) begin
            status_r <= ST_RANGE;
            state    <= S_FINISH;
          end else begin
            status_r <= ST_DONE;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            ri <= ri + 1'b1;
          end
          dv <= issue;
          di <= ri[IDX_W-1:0];
          if (dv) begin
            if (!found && rdata.base <= start_r && start_r <= rdata.last) begin
              found    <= 1'b1;
              hit_idx  <= di;
              hit_base <= rdata.base;
              hit_last <= rdata.last;
            end
            if (rdata.base <= last_r && start_r <= rdata.last) begin
              ovl <= 1'b1;
            end
            if (start_r != 64'd0 && rdata.last == startm1) begin
              lo_f    <= 1'b1;
              lo_idx  <= di;
              lo_base <= rdata.base;
            end
            if (last_r < ADDR_MASK && rdata.base == lastp1) begin
              hi_f    <= 1'b1;
              hi_idx  <= di;
              hi_last <= rdata.last;
            end
            if (!pos_f && rdata.base > start_r) begin
              pos_f   <= 1'b1;
              pos_idx <= CNT_W'(di);
            end
          end
          if (!issue && !dv) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          m_base <= mbase;
          m_last <= mlast;
          if (act == ACT_ALLOC) begin
            if (!found || hit_last < last_r) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else if (hit_left && hit_right && full) begin
              status_r <= ST_FULL;
              state    <= S_FINISH;
            end else begin
              // A split opens a slot above the hit; an exact match closes the hit's own slot.
              state   <= S_WR1;
              w1_en   <= hit_left || hit_right;
              w1_a    <= hit_idx;
              w1_d    <= hit_left ? extent_t'{base: hit_base, last: startm1}
                                  : extent_t'{base: lastp1, last: hit_last};
              w2_en   <= hit_left && hit_right;
              w2_a    <= IDX_W'(CNT_W'(hit_idx) + 1'b1);
              w2_d    <= extent_t'{base: lastp1, last: hit_last};
              sh_en   <= (hit_left == hit_right);
              sh_open <= hit_left && hit_right;
              sc      <= (hit_left && hit_right) ? n - 1'b1
                                                 : CNT_W'(hit_idx) + 1'b1;
              rem     <= (hit_left && hit_right) ? n - (CNT_W'(hit_idx) + 1'b1)
                                                 : n - 1'b1 - CNT_W'(hit_idx);
            end
          end else begin
            if (ovl || whole_space) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else if (!lo_f && !hi_f && full) begin
              status_r <= ST_FULL;
              state    <= S_FINISH;
            end else begin
              // No neighbor opens a slot; two neighbors close the upper one.
              state   <= S_WR1;
              merged  <= 1'b1;
              w1_en   <= lo_f || hi_f;
              w1_a    <= lo_f ? lo_idx : hi_idx;
              w1_d    <= extent_t'{base: mbase, last: mlast};
              w2_en   <= !lo_f && !hi_f;
              w2_a    <= pos_f ? pos_idx[IDX_W-1:0] : n[IDX_W-1:0];
              w2_d    <= extent_t'{base: mbase, last: mlast};
              sh_en   <= (lo_f == hi_f);
              sh_open <= !lo_f && !hi_f;
              sc      <= (!lo_f && !hi_f) ? n - 1'b1 : CNT_W'(hi_idx) + 1'b1;
              rem     <= (!lo_f && !hi_f) ? n - (pos_f ? pos_idx : n)
                                          : n - 1'b1 - CNT_W'(hi_idx);
            end
          end
        end
        S_WR1: begin
          dv    <= 1'b0;
          state <= sh_en ? S_SHIFT : S_WR2;
        end
        S_SHIFT: begin
          // Opening moves entries up one slot from the top down; closing
          // moves them down one slot from the hole upward.
          if (sh_issue) begin
            rem <= rem - 1'b1;
            sc  <= sh_open ? sc - 1'b1 : sc + 1'b1;
            wa  <= sh_open ? IDX_W'(sc + 1'b1) : IDX_W'(sc - 1'b1);
          end
          dv <= sh_issue;
          if (!sh_issue && !dv) begin
            state <= S_WR2;
          end
        end
        S_WR2: begin
          if (sh_en) begin
            n <= sh_open ? n + 1'b1 : n - 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= status_r;
            merged_start <= merged ? m_base : 64'd0;
            merged_size  <= merged ? (m_last - m_base + 64'd1) : 64'd0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CFET_ASSERT(a_count_bound, n <= CNT_W'(MAX_EXTENTS))
  `CFET_ASSERT_IMP(a_write_state, mem_req.we,
                   state == S_WR1 || state == S_WR2 || state == S_SHIFT)
  `CFET_ASSERT_IMP(a_count_change, !$past(rst) && n != $past(n), $past(state) == S_WR2)
  `CFET_ASSERT_IMP(a_full_no_open, state == S_SHIFT && sh_open, !full)

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free extent table: a queue-fed driver sends
// alloc and free words, a predictor keeps its own sorted extent list, and a
// monitor compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfet_pkg::*;

  typedef struct packed {
    logic        act;
    logic [63:0] saddr;
    logic [63:0] len;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] mstart;
    logic [63:0] msize;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [63:0] start_address = '0;
  logic [63:0] length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] merged_start;
  logic [63:0] merged_size;

  req_t        pending_words[$];
  rsp_t        expected_rsps[$];
  logic [63:0] free_base[$];
  logic [63:0] free_last[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_go = 1'b0;
  bit          hold_used = 1'b0;
  bit          quiet = 1'b0;

  coalescing_free_extent_table dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicts one word against the free list kept as base and inclusive last.
  function automatic rsp_t predict_extent_op(req_t r);
    rsp_t        o;
    logic [63:0] last;
    logic [64:0] sum;
    int          n, hit, lo, hi, pos;
    logic [63:0] b, l, mb, ml, msz;
    o = '0;
    n = free_base.size();
    if (r.len == 0) return o;
    sum = {1'b0, r.saddr} + {1'b0, r.len} - 65'd1;
    last = sum[63:0];
    if (sum[64] || r.saddr > ADDR_MASK || last > ADDR_MASK) begin
      o.st = ST_RANGE;
      return o;
    end
    if (r.act == ACT_ALLOC) begin
      hit = -1;
      for (int i = 0; i < n; i++)
        if (hit < 0 && free_base[i] <= r.saddr && r.saddr <= free_last[i]) hit = i;
      if (hit < 0 || free_last[hit] < last) begin
        o.st = ST_RANGE;
        return o;
      end
      b = free_base[hit];
      l = free_last[hit];
      if (b < r.saddr && l > last) begin
        if (n >= MAX_EXTENTS) begin
          o.st = ST_FULL;
          return o;
        end
        free_last[hit] = r.saddr - 64'd1;
        free_base.insert(hit + 1, last + 64'd1);
        free_last.insert(hit + 1, l);
      end else if (b < r.saddr) begin
        free_last[hit] = r.saddr - 64'd1;
      end else if (l > last) begin
        free_base[hit] = last + 64'd1;
      end else begin
        free_base.delete(hit);
        free_last.delete(hit);
      end
      return o;
    end
    lo = -1;
    hi = -1;
    pos = n;
    for (int i = 0; i < n; i++) begin
      b = free_base[i];
      l = free_last[i];
      if (b <= last && r.saddr <= l) begin
        o.st = ST_RANGE;
        return o;
      end
      if (r.saddr > 0 && l == r.saddr - 64'd1) lo = i;
      if (last < ADDR_MASK && b == last + 64'd1) hi = i;
      if (pos == n && b > r.saddr) pos = i;
    end
    mb = (lo >= 0) ? free_base[lo] : r.saddr;
    ml = (hi >= 0) ? free_last[hi] : last;
    msz = ml - mb + 64'd1;
    if (msz == 0) begin
      o.st = ST_RANGE;
      return o;
    end
    if (lo < 0 && hi < 0) begin
      if (n >= MAX_EXTENTS) begin
        o.st = ST_FULL;
        return o;
      end
      free_base.insert(pos, mb);
      free_last.insert(pos, ml);
    end else if (lo >= 0) begin
      free_last[lo] = ml;
      if (hi >= 0) begin
        free_base.delete(hi);
        free_last.delete(hi);
      end
    end else begin
      free_base[hi] = mb;
    end
    o.mstart = mb;
    o.msize = msz;
    return o;
  endfunction

  function automatic req_t mk(logic a, logic [63:0] s, logic [63:0] l);
    req_t r;
    r.act = a;
    r.saddr = s;
    r.len = l;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: feeds queued words, with random gaps while not in the quiet tail.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        req_t r;
        r = pending_words.pop_front();
        expected_rsps.push_back(predict_extent_op(r));
        in_valid <= 1'b1;
        action <= r.act;
        start_address <= r.saddr;
        length <= r.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted on its own once requested.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_left <= 600;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result word: status %0d", status);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e.st !== status || e.mstart !== merged_start || e.msize !== merged_size) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %0d %h %h, got %0d %h %h",
                       e.st, e.mstart, e.msize, status, merged_start, merged_size);
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] s, l;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Directed: zero length, range wrap, empty-table alloc, merges, splits.
    pending_words.push_back(mk(ACT_ALLOC, 64'h10, 64'd0));
    pending_words.push_back(mk(ACT_FREE, 64'h0, 64'd0));
    pending_words.push_back(mk(ACT_FREE, '1, 64'd2));
    pending_words.push_back(mk(ACT_ALLOC, '1, '1));
    pending_words.push_back(mk(ACT_ALLOC, 64'h100, 64'd16));
    pending_words.push_back(mk(ACT_FREE, 64'h1000, 64'h100));
    pending_words.push_back(mk(ACT_FREE, 64'h1080, 64'd4));
    pending_words.push_back(mk(ACT_FREE, 64'h0F00, 64'h100));
    pending_words.push_back(mk(ACT_FREE, 64'h1200, 64'h100));
    pending_words.push_back(mk(ACT_FREE, 64'h1100, 64'h100));
    pending_words.push_back(mk(ACT_ALLOC, 64'h1100, 64'h10));
    pending_words.push_back(mk(ACT_ALLOC, 64'h0F00, 64'h10));
    pending_words.push_back(mk(ACT_ALLOC, 64'h12F0, 64'h10));
    pending_words.push_back(mk(ACT_ALLOC, 64'h0F10, 64'h1F0));
    pending_words.push_back(mk(ACT_ALLOC, 64'h1110, 64'h1E0));
    pending_words.push_back(mk(ACT_FREE, 64'h0, 64'h8000_0000_0000_0000));
    pending_words.push_back(mk(ACT_FREE, '1, 64'd1));
    // The merge that would cover the whole space is rejected.
    pending_words.push_back(mk(ACT_FREE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
    pending_words.push_back(mk(ACT_ALLOC, 64'h0, '1));
    pending_words.push_back(mk(ACT_ALLOC, 64'h0, 64'h8000_0000_0000_0000));
    pending_words.push_back(mk(ACT_ALLOC, '1, 64'd1));
    // Fill the table with isolated extents, then hit the full case both ways.
    for (int i = 0; i < 66; i++)
      pending_words.push_back(mk(ACT_FREE, 64'h10_0000 + i * 64'h100, 64'h10));
    pending_words.push_back(mk(ACT_ALLOC, 64'h10_0004, 64'd4));
    pending_words.push_back(mk(ACT_ALLOC, 64'h10_0000, 64'h10));
    for (int i = 0; i < 64; i++)
      pending_words.push_back(mk(ACT_ALLOC, 64'h10_0000 + i * 64'h100, 64'h10));
    // Random part: mostly small ranges in a narrow window so merges and splits
    // are frequent, plus wide random noise.
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        s = rnd64();
        l = rnd64() >> $urandom_range(0, 63);
      end else begin
        s = ($urandom_range(0, 3) == 0 ? '1 - 64'h400 : 64'h0)
            + 64'($urandom_range(0, 1023));
        l = 64'($urandom_range(0, 40));
      end
      pending_words.push_back(mk(1'($urandom_range(0, 1)), s, l));
    end
    // Long receiver hold so the block backs up its input.
    wait (pending_words.size() < 400);
    @(posedge clk);
    hold_go = 1'b1;
    wait (pending_words.size() < 60);
    quiet = 1'b1;
    wait (pending_words.size() == 0 && expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
